FILE: sv/bdut_pkg.sv
package bdut_pkg;

	localparam int NODE_BITS  = 12;
	localparam int NODE_COUNT = 4096;
	localparam int BKT_BITS   = 10;
	localparam int BKT_COUNT  = 1024;
	localparam int LEVEL_BITS = 16;
	localparam int REF_BITS   = 16;
	localparam int STEP_BITS  = NODE_BITS + 1;

	localparam logic [31:0]           HASH_MOD   = 32'hffff_fffb;
	localparam logic [REF_BITS-1:0]   REF_MAX    = '1;
	localparam logic [LEVEL_BITS-1:0] LEVEL_FREE = '1;
	localparam logic [NODE_BITS-1:0]  NODE_LAST  = NODE_BITS'(NODE_COUNT - 1);

	typedef enum logic [1:0] {
		OP_MAKE = 2'd0,
		OP_INC  = 2'd1,
		OP_REL  = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_ZERO    = 2'd3
	} status_t;

	// work class decided in the front end
	typedef enum logic [2:0] {
		K_NOP,
		K_INC,
		K_REL,
		K_EQ,
		K_MAKE
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [LEVEL_BITS-1:0] lev;
		logic [NODE_BITS-1:0]  lo;
		logic [NODE_BITS-1:0]  hi;
		logic [NODE_BITS-1:0]  tgt;
		logic [BKT_BITS-1:0]   bkt;
	} cmd_t;

	typedef struct packed {
		logic [NODE_BITS-1:0]  node_index;
		status_t               status;
		logic [LEVEL_BITS-1:0] var_count;
	} res_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic [NODE_BITS-1:0]  low;
		logic [NODE_BITS-1:0]  high;
		logic [NODE_BITS-1:0]  link;
		logic [REF_BITS-1:0]   refs;
	} node_t;

endpackage

FILE: sv/bdut_fifo.sv
module bdut_fifo import bdut_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW:0]  wr_q, rd_q;
	logic [AW:0]  diff;

	assign diff  = wr_q - rd_q;
	assign full  = diff == (AW+1)'(DEPTH);
	assign empty = diff == '0;
	assign dout  = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (pop && !empty) rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q[AW-1:0]] <= din;
	end

endmodule

FILE: sv/bdut_hash.sv
module bdut_hash import bdut_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [LEVEL_BITS-1:0] lev,
	input  logic [NODE_BITS-1:0]  lo,
	input  logic [NODE_BITS-1:0]  hi,
	output logic                  out_valid,
	output logic [BKT_BITS-1:0]   bkt
);

	// pair(lo,hi) stays far below the modulus, so only the outer pair reduces
	logic [25:0] sa, j, s;
	logic [51:0] s52;
	logic [31:0] x, xm;

	logic                  v_s1, v_s2, v_s3;
	logic [25:0]           p1_s1;
	logic [NODE_BITS-1:0]  lo_s1;
	logic [LEVEL_BITS-1:0] lev_s1, lev_s2;
	logic [51:0]           p2_s2;
	logic [BKT_BITS-1:0]   bkt_s3;

	assign sa  = 26'(lo) + 26'(hi);
	assign j   = {1'b0, p1_s1[25:1]} + 26'(lo_s1);
	assign s   = j + 26'(lev_s1);
	assign s52 = 52'(s);
	assign x   = p2_s2[32:1] + 32'(lev_s2);
	assign xm  = (x >= HASH_MOD) ? x - HASH_MOD : x;

	assign out_valid = v_s3;
	assign bkt       = bkt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1  <= sa * (sa + 26'd1);
			lo_s1  <= lo;
			lev_s1 <= lev;
			p2_s2  <= s52 * (s52 + 52'd1);
			lev_s2 <= lev_s1;
			bkt_s3 <= xm[BKT_BITS-1:0];
		end
	end

endmodule

FILE: sv/bdut_front.sv
module bdut_front import bdut_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  busy,
	input  logic [1:0]            op,
	input  logic [LEVEL_BITS-1:0] var_level,
	input  logic [NODE_BITS-1:0]  low_child,
	input  logic [NODE_BITS-1:0]  high_child,
	input  logic [NODE_BITS-1:0]  target_node,
	input  logic                  q_full,
	output logic                  q_push,
	output cmd_t                  q_data
);

	logic                adv, acc, v3;
	kind_t               kind;
	logic [BKT_BITS-1:0] bkt;
	cmd_t                cmd_in, cmd_s1, cmd_s2, cmd_s3;

	assign adv    = !(v3 && q_full);
	assign full   = !adv || busy;
	assign acc    = push && !full;
	assign q_push = v3 && !q_full;

	always_comb begin
		unique case (op_t'(op))
			OP_MAKE: kind = (low_child == high_child) ? K_EQ : K_MAKE;
			OP_INC:  kind = K_INC;
			OP_REL:  kind = K_REL;
			OP_NOP:  kind = K_NOP;
			default: kind = K_NOP;
		endcase
	end

	always_comb begin
		cmd_in      = '0;
		cmd_in.kind = kind;
		cmd_in.lev  = var_level;
		cmd_in.lo   = low_child;
		cmd_in.hi   = high_child;
		cmd_in.tgt  = target_node;
		q_data      = cmd_s3;
		q_data.bkt  = bkt;
	end

	bdut_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (acc),
		.lev      (var_level),
		.lo       (low_child),
		.hi       (high_child),
		.out_valid(v3),
		.bkt      (bkt)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_in;
			cmd_s2 <= cmd_s1;
			cmd_s3 <= cmd_s2;
		end
	end

endmodule

FILE: sv/bdut_back.sv
module bdut_back import bdut_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	output logic q_pop,
	input  cmd_t q_data,
	input  logic r_full,
	output logic r_push,
	output res_t r_data,
	output logic busy
);

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DONE, S_REL_END,
		S_F0, S_F1, S_FCHK, S_FCMP,
		S_ALLOC, S_AL1, S_AL2, S_LZ2,
		S_MKW, S_MKBL, S_MKBH, S_MKHD, S_MKLN,
		S_B0, S_B1,
		S_R0, S_R1, S_RHASH, S_R2, S_RWALK, S_RWCMP, S_RFREE, S_RF1, S_RF2
	} state_t;

	localparam logic [STEP_BITS-1:0] STEP_LIMIT = STEP_BITS'(NODE_COUNT);

	state_t                state_q, bret_q, rret_q;
	cmd_t                  cmd_q;
	logic [NODE_BITS-1:0]  clr_q, n_q, p_q, bx_q, rx_q, idx_q, free_tail_q;
	logic [NODE_BITS-1:0]  oldhi_q;
	logic [STEP_BITS-1:0]  steps_q;
	logic [BKT_BITS-1:0]   rb_q;
	logic [LEVEL_BITS:0]   lvl_q;
	status_t               stat_q, rstat_q;
	node_t                 rword_q, twrd_q;

	node_t                 node_mem [NODE_COUNT];
	logic [NODE_BITS-1:0]  bkt_mem  [BKT_COUNT];
	node_t                 nrd_q, nwr_data;
	logic [NODE_BITS-1:0]  bhd_q, bwr_data;
	logic                  nrd_en, nwr_en, brd_en, bwr_en;
	logic [NODE_BITS-1:0]  nrd_addr, nwr_addr;
	logic [BKT_BITS-1:0]   brd_addr, bwr_addr;

	logic                  h_start, h_valid, match;
	logic [BKT_BITS-1:0]   h_bkt;

	function automatic node_t init_node(input logic [NODE_BITS-1:0] i);
		node_t w;
		w       = '0;
		w.level = LEVEL_FREE;
		if (i == NODE_BITS'(1)) begin
			w.low  = NODE_BITS'(1);
			w.high = NODE_BITS'(1);
		end
		if (i <= NODE_BITS'(1)) w.refs = REF_BITS'(2);
		if (i == NODE_LAST) w.link = NODE_BITS'(2);
		else if (i >= NODE_BITS'(2)) w.link = i + 1'b1;
		return w;
	endfunction

	assign busy   = state_q == S_INIT;
	assign q_pop  = state_q == S_IDLE && !q_empty;
	assign r_push = state_q == S_DONE && !r_full;
	assign match  = nrd_q.level == cmd_q.lev && nrd_q.low == cmd_q.lo && nrd_q.high == cmd_q.hi;
	assign h_start = state_q == S_R1 && nrd_q.refs == REF_BITS'(1);

	always_comb begin
		r_data            = '0;
		r_data.node_index = idx_q;
		r_data.status     = stat_q;
		r_data.var_count  = lvl_q[LEVEL_BITS] ? '1 : lvl_q[LEVEL_BITS-1:0];
	end

	// hash of the node being freed, taken straight from the read word
	bdut_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (1'b1),
		.in_valid (h_start),
		.lev      (nrd_q.level),
		.lo       (nrd_q.low),
		.hi       (nrd_q.high),
		.out_valid(h_valid),
		.bkt      (h_bkt)
	);

	// memory port control
	always_comb begin
		nrd_en   = 1'b0;
		nrd_addr = '0;
		nwr_en   = 1'b0;
		nwr_addr = '0;
		nwr_data = nrd_q;
		brd_en   = 1'b0;
		brd_addr = '0;
		bwr_en   = 1'b0;
		bwr_addr = '0;
		bwr_data = '0;
		case (state_q)
			S_INIT: begin
				nwr_en   = 1'b1;
				nwr_addr = clr_q;
				nwr_data = init_node(clr_q);
				bwr_en   = clr_q < NODE_BITS'(BKT_COUNT);
				bwr_addr = clr_q[BKT_BITS-1:0];
			end
			S_F0: begin
				brd_en   = 1'b1;
				brd_addr = cmd_q.bkt;
			end
			S_FCHK, S_RWALK: begin
				nrd_en   = p_q != '0 && steps_q != STEP_LIMIT;
				nrd_addr = p_q;
			end
			S_ALLOC: begin
				nrd_en   = free_tail_q != '0;
				nrd_addr = free_tail_q;
			end
			S_AL1: begin
				nrd_en   = 1'b1;
				nrd_addr = nrd_q.link;
			end
			S_AL2: begin
				nwr_en        = nrd_q.link != n_q;
				nwr_addr      = free_tail_q;
				nwr_data      = twrd_q;
				nwr_data.link = nrd_q.link;
			end
			S_MKW: begin
				nwr_en         = 1'b1;
				nwr_addr       = n_q;
				nwr_data       = '0;
				nwr_data.level = cmd_q.lev;
				nwr_data.low   = cmd_q.lo;
				nwr_data.high  = cmd_q.hi;
			end
			S_MKHD: begin
				brd_en   = 1'b1;
				brd_addr = cmd_q.bkt;
				nrd_en   = 1'b1;
				nrd_addr = n_q;
			end
			S_MKLN: begin
				nwr_en        = 1'b1;
				nwr_addr      = n_q;
				nwr_data.link = bhd_q;
				if (nrd_q.refs != REF_MAX) nwr_data.refs = nrd_q.refs + 1'b1;
				bwr_en        = 1'b1;
				bwr_addr      = cmd_q.bkt;
				bwr_data      = n_q;
			end
			S_B0: begin
				nrd_en   = 1'b1;
				nrd_addr = bx_q;
			end
			S_B1: begin
				nwr_en        = nrd_q.refs != REF_MAX;
				nwr_addr      = bx_q;
				nwr_data.refs = nrd_q.refs + 1'b1;
			end
			S_R0: begin
				nrd_en   = rx_q > NODE_BITS'(1);
				nrd_addr = rx_q;
			end
			S_R1: begin
				nwr_en        = nrd_q.refs != '0 && nrd_q.refs != REF_MAX;
				nwr_addr      = rx_q;
				nwr_data.refs = nrd_q.refs - 1'b1;
			end
			S_RHASH: begin
				brd_en   = h_valid;
				brd_addr = h_bkt;
			end
			S_R2: begin
				bwr_en   = bhd_q == rx_q;
				bwr_addr = rb_q;
				bwr_data = rword_q.link;
			end
			S_RWCMP: begin
				nwr_en        = nrd_q.link == rx_q;
				nwr_addr      = p_q;
				nwr_data.link = rword_q.link;
			end
			S_RFREE: begin
				nrd_en         = free_tail_q != '0;
				nrd_addr       = free_tail_q;
				nwr_en         = free_tail_q == '0;
				nwr_addr       = rx_q;
				nwr_data       = rword_q;
				nwr_data.level = LEVEL_FREE;
				nwr_data.link  = rx_q;
			end
			S_RF1: begin
				nwr_en         = 1'b1;
				nwr_addr       = rx_q;
				nwr_data       = rword_q;
				nwr_data.level = LEVEL_FREE;
				nwr_data.link  = nrd_q.link;
			end
			S_RF2: begin
				nwr_en        = 1'b1;
				nwr_addr      = free_tail_q;
				nwr_data      = twrd_q;
				nwr_data.link = rx_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nwr_en) node_mem[nwr_addr] <= nwr_data;
		if (nrd_en) nrd_q <= node_mem[nrd_addr];
	end

	always_ff @(posedge clk) begin
		if (bwr_en) bkt_mem[bwr_addr] <= bwr_data;
		if (brd_en) bhd_q <= bkt_mem[brd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			bret_q      <= S_DONE;
			rret_q      <= S_DONE;
			clr_q       <= '0;
			free_tail_q <= NODE_LAST;
			lvl_q       <= '0;
			stat_q      <= ST_OK;
			rstat_q     <= ST_OK;
			idx_q       <= '0;
			steps_q     <= '0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == NODE_LAST) state_q <= S_IDLE;
				end
				S_IDLE: if (!q_empty) begin
					cmd_q  <= q_data;
					stat_q <= ST_OK;
					idx_q  <= '0;
					case (q_data.kind)
						K_INC: begin
							bx_q    <= q_data.tgt;
							bret_q  <= S_DONE;
							state_q <= (q_data.tgt > NODE_BITS'(1)) ? S_B0 : S_DONE;
						end
						K_REL: begin
							rx_q    <= q_data.tgt;
							rret_q  <= S_REL_END;
							state_q <= S_R0;
						end
						K_EQ: begin
							idx_q   <= q_data.lo;
							bx_q    <= q_data.lo;
							bret_q  <= S_DONE;
							state_q <= S_B0;
						end
						K_MAKE:  state_q <= S_F0;
						default: state_q <= S_DONE;
					endcase
				end
				S_DONE: if (!r_full) state_q <= S_IDLE;
				S_REL_END: begin
					stat_q  <= rstat_q;
					state_q <= S_DONE;
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					p_q     <= bhd_q;
					steps_q <= '0;
					state_q <= S_FCHK;
				end
				S_FCHK: state_q <= (p_q == '0 || steps_q == STEP_LIMIT) ? S_ALLOC : S_FCMP;
				S_FCMP: begin
					if (match) begin
						idx_q   <= p_q;
						bx_q    <= p_q;
						bret_q  <= S_DONE;
						state_q <= S_B0;
					end else begin
						p_q     <= nrd_q.link;
						steps_q <= steps_q + 1'b1;
						state_q <= S_FCHK;
					end
				end
				S_ALLOC: begin
					if (free_tail_q == '0) begin
						stat_q  <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						if ({1'b0, cmd_q.lev} >= lvl_q) lvl_q <= {1'b0, cmd_q.lev} + 1'b1;
						state_q <= S_AL1;
					end
				end
				S_AL1: begin
					n_q     <= nrd_q.link;
					twrd_q  <= nrd_q;
					state_q <= S_AL2;
				end
				S_AL2: begin
					oldhi_q <= nrd_q.high;
					if (nrd_q.link == n_q) free_tail_q <= '0;
					rx_q    <= nrd_q.low;
					rret_q  <= S_LZ2;
					state_q <= S_R0;
				end
				S_LZ2: begin
					rx_q    <= oldhi_q;
					rret_q  <= S_MKW;
					state_q <= S_R0;
				end
				S_MKW: state_q <= S_MKBL;
				S_MKBL: begin
					bx_q    <= cmd_q.lo;
					bret_q  <= S_MKBH;
					state_q <= (cmd_q.lo > NODE_BITS'(1)) ? S_B0 : S_MKBH;
				end
				S_MKBH: begin
					bx_q    <= cmd_q.hi;
					bret_q  <= S_MKHD;
					state_q <= (cmd_q.hi > NODE_BITS'(1)) ? S_B0 : S_MKHD;
				end
				S_MKHD: state_q <= S_MKLN;
				S_MKLN: begin
					idx_q   <= n_q;
					state_q <= S_DONE;
				end
				S_B0: state_q <= S_B1;
				S_B1: state_q <= bret_q;
				S_R0: begin
					rstat_q <= ST_OK;
					state_q <= (rx_q > NODE_BITS'(1)) ? S_R1 : rret_q;
				end
				S_R1: begin
					if (nrd_q.refs == '0) begin
						rstat_q <= ST_ZERO;
						state_q <= rret_q;
					end else if (nrd_q.refs == REF_BITS'(1)) begin
						rword_q      <= nrd_q;
						rword_q.refs <= '0;
						state_q      <= S_RHASH;
					end else begin
						state_q <= rret_q;
					end
				end
				S_RHASH: if (h_valid) begin
					rb_q    <= h_bkt;
					state_q <= S_R2;
				end
				S_R2: begin
					p_q     <= bhd_q;
					steps_q <= '0;
					state_q <= (bhd_q == rx_q) ? S_RFREE : S_RWALK;
				end
				S_RWALK: begin
					if (p_q == '0 || steps_q == STEP_LIMIT) begin
						rstat_q <= ST_MISSING;
						state_q <= rret_q;
					end else begin
						state_q <= S_RWCMP;
					end
				end
				S_RWCMP: begin
					if (nrd_q.link == rx_q) begin
						state_q <= S_RFREE;
					end else begin
						p_q     <= nrd_q.link;
						steps_q <= steps_q + 1'b1;
						state_q <= S_RWALK;
					end
				end
				S_RFREE: begin
					if (free_tail_q == '0) begin
						free_tail_q <= rx_q;
						state_q     <= rret_q;
					end else begin
						state_q <= S_RF1;
					end
				end
				S_RF1: begin
					twrd_q  <= nrd_q;
					state_q <= S_RF2;
				end
				S_RF2: begin
					free_tail_q <= rx_q;
					state_q     <= rret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_tail_not_const: assert property (@(posedge clk) disable iff (!arst_n)
		free_tail_q != NODE_BITS'(1))
		else $error("free list tail points at a constant node");

	a_push_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		r_push |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after result transfer");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= STEP_LIMIT)
		else $error("chain walk ran past its step limit");

	a_no_pop_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == S_INIT) && state_q == S_INIT |-> !q_pop && free_tail_q == NODE_LAST)
		else $error("work taken during clearing pass");

endmodule

FILE: sv/bdd_unique_node_table_core.sv
// Channel   Handshake           Fields
// input     push / full         op, var_level, low_child, high_child, target_node
// result    empty / pop         node_index, status, var_count
//
// Reset clears the node and bucket memories in a pass over all 4096 node entries (one
//   node entry a cycle, buckets alongside); full stays high for that pass.
// Front end hash is registered and feeds a 4-deep command queue; results go through a
//   2-deep queue, so the back end finishes the next item while a result waits for pop.
// Back end, one item at a time: release and make of an existing node grow with each
//   chain step walked; allocation also runs two lazy releases of the reused node's old
//   children.
module bdd_unique_node_table_core import bdut_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            op,
	input  logic [LEVEL_BITS-1:0] var_level,
	input  logic [NODE_BITS-1:0]  low_child,
	input  logic [NODE_BITS-1:0]  high_child,
	input  logic [NODE_BITS-1:0]  target_node,
	output logic                  empty,
	input  logic                  pop,
	output logic [NODE_BITS-1:0]  node_index,
	output logic [1:0]            status,
	output logic [LEVEL_BITS-1:0] var_count
);

	localparam int CW = $bits(cmd_t);
	localparam int RW = $bits(res_t);

	// front end to command queue
	logic          fq_push, fq_full, busy;
	cmd_t          fq_data;
	// command queue to back end
	logic          bq_empty, bq_pop;
	logic [CW-1:0] bq_bits;
	// back end to result queue
	logic          r_push, r_full;
	res_t          r_data, r_head;
	logic [RW-1:0] r_bits;

	bdut_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.busy       (busy),
		.op         (op),
		.var_level  (var_level),
		.low_child  (low_child),
		.high_child (high_child),
		.target_node(target_node),
		.q_full     (fq_full),
		.q_push     (fq_push),
		.q_data     (fq_data)
	);

	bdut_fifo #(.W(CW), .DEPTH(4)) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fq_push),
		.din   (fq_data),
		.full  (fq_full),
		.pop   (bq_pop),
		.dout  (bq_bits),
		.empty (bq_empty)
	);

	bdut_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(bq_empty),
		.q_pop  (bq_pop),
		.q_data (cmd_t'(bq_bits)),
		.r_full (r_full),
		.r_push (r_push),
		.r_data (r_data),
		.busy   (busy)
	);

	bdut_fifo #(.W(RW), .DEPTH(2)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (r_push),
		.din   (r_data),
		.full  (r_full),
		.pop   (pop),
		.dout  (r_bits),
		.empty (empty)
	);

	assign r_head     = res_t'(r_bits);
	assign node_index = r_head.node_index;
	assign status     = r_head.status;
	assign var_count  = r_head.var_count;

endmodule

FILE: test/bdd_unique_node_table_core_test.sv
module bdd_unique_node_table_core_test;
	import bdut_pkg::*;

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Block ports
	logic                  push = 1'b0;
	logic                  full;
	logic [1:0]            op = OP_NOP;
	logic [LEVEL_BITS-1:0] var_level = '0;
	logic [NODE_BITS-1:0]  low_child = '0;
	logic [NODE_BITS-1:0]  high_child = '0;
	logic [NODE_BITS-1:0]  target_node = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [NODE_BITS-1:0]  node_index;
	logic [1:0]            status;
	logic [LEVEL_BITS-1:0] var_count;

	bdd_unique_node_table_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.var_level   (var_level),
		.low_child   (low_child),
		.high_child  (high_child),
		.target_node (target_node),
		.empty       (empty),
		.pop         (pop),
		.node_index  (node_index),
		.status      (status),
		.var_count   (var_count)
	);

	// Shadow copy of the unique table, kept in step with accepted transfers
	logic [LEVEL_BITS-1:0] sh_level [NODE_COUNT];
	logic [NODE_BITS-1:0]  sh_low   [NODE_COUNT];
	logic [NODE_BITS-1:0]  sh_high  [NODE_COUNT];
	logic [NODE_BITS-1:0]  sh_link  [NODE_COUNT];
	logic [REF_BITS-1:0]   sh_refs  [NODE_COUNT];
	logic [NODE_BITS-1:0]  sh_bucket [BKT_COUNT];
	logic [NODE_BITS-1:0]  sh_free_tail;
	logic [16:0]           sh_levels;

	res_t expected_q [$];
	int   err_count = 0;
	int   quiet_cycles = 0;
	bit   idle_enable = 1'b1;

	// Directed rows; chk set where the result is typed in rather than predicted
	typedef struct {
		op_t                   o;
		logic [LEVEL_BITS-1:0] lv;
		logic [NODE_BITS-1:0]  lo;
		logic [NODE_BITS-1:0]  hi;
		logic [NODE_BITS-1:0]  tg;
		bit                    chk;
		res_t                  want;
	} row_t;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	function automatic logic [31:0] pair_code(input logic [63:0] i, input logic [63:0] j);
		logic [63:0] s;
		logic [31:0] t;
		s = (i % 64'(HASH_MOD)) + (j % 64'(HASH_MOD));
		s = s * (s + 64'd1);
		t = 32'((s >> 1) + i);
		return t % HASH_MOD;
	endfunction

	function automatic logic [BKT_BITS-1:0] bucket_of(input logic [LEVEL_BITS-1:0] lv,
			input logic [NODE_BITS-1:0] lo, input logic [NODE_BITS-1:0] hi);
		return BKT_BITS'(pair_code(64'(lv), 64'(pair_code(64'(lo), 64'(hi)))));
	endfunction

	// Indexes are 12 bits wide and NODE_COUNT is 4096, so every index names a node
	function automatic void bump_refs(input logic [NODE_BITS-1:0] n);
		if (sh_refs[n] != REF_MAX)
			sh_refs[n]++;
	endfunction

	function automatic logic [NODE_BITS-1:0] chain_find(input logic [LEVEL_BITS-1:0] lv,
			input logic [NODE_BITS-1:0] lo, input logic [NODE_BITS-1:0] hi);
		logic [NODE_BITS-1:0] p;
		int steps;
		p = sh_bucket[bucket_of(lv, lo, hi)];
		steps = 0;
		while (p != 0 && steps < NODE_COUNT) begin
			if (sh_level[p] == lv && sh_low[p] == lo && sh_high[p] == hi)
				return p;
			p = sh_link[p];
			steps++;
		end
		return '0;
	endfunction

	function automatic bit chain_unlink(input logic [NODE_BITS-1:0] n);
		logic [BKT_BITS-1:0]  b;
		logic [NODE_BITS-1:0] p, nx;
		int steps;
		b = bucket_of(sh_level[n], sh_low[n], sh_high[n]);
		p = sh_bucket[b];
		steps = 0;
		if (p == n) begin
			sh_bucket[b] = sh_link[n];
			return 1'b1;
		end
		while (p != 0 && steps < NODE_COUNT) begin
			nx = sh_link[p];
			if (nx == n) begin
				sh_link[p] = sh_link[n];
				return 1'b1;
			end
			p = nx;
			steps++;
		end
		return 1'b0;
	endfunction

	function automatic status_t drop_ref(input logic [NODE_BITS-1:0] n);
		if (n <= 1)
			return ST_OK;
		if (sh_refs[n] == 0)
			return ST_ZERO;
		if (sh_refs[n] == REF_MAX)
			return ST_OK;
		sh_refs[n]--;
		if (sh_refs[n] != 0)
			return ST_OK;
		if (!chain_unlink(n))
			return ST_MISSING;
		sh_level[n] = LEVEL_FREE;
		if (sh_free_tail == 0) begin
			sh_link[n] = n;
		end else begin
			sh_link[n] = sh_link[sh_free_tail];
			sh_link[sh_free_tail] = n;
		end
		sh_free_tail = n;
		return ST_OK;
	endfunction

	function automatic res_t make_node(input logic [LEVEL_BITS-1:0] lv,
			input logic [NODE_BITS-1:0] lo, input logic [NODE_BITS-1:0] hi);
		res_t r;
		logic [NODE_BITS-1:0] n;
		logic [BKT_BITS-1:0]  b;
		status_t dummy;
		r = '0;
		r.status = ST_OK;
		if (lo == hi) begin
			bump_refs(lo);
			r.node_index = lo;
			return r;
		end
		n = chain_find(lv, lo, hi);
		if (n != 0) begin
			bump_refs(n);
			r.node_index = n;
			return r;
		end
		if (sh_free_tail == 0) begin
			r.status = ST_FULL;
			return r;
		end
		if (17'(lv) >= sh_levels)
			sh_levels = 17'(lv) + 17'd1;
		n = sh_link[sh_free_tail];
		if (n == sh_link[n])
			sh_free_tail = '0;
		else
			sh_link[sh_free_tail] = sh_link[n];
		// old children are released only now, on reuse
		if (sh_low[n] > 1)
			dummy = drop_ref(sh_low[n]);
		if (sh_high[n] > 1)
			dummy = drop_ref(sh_high[n]);
		sh_level[n] = lv;
		sh_low[n] = lo;
		sh_high[n] = hi;
		sh_refs[n] = '0;
		if (lo > 1)
			bump_refs(lo);
		if (hi > 1)
			bump_refs(hi);
		b = bucket_of(lv, lo, hi);
		sh_link[n] = sh_bucket[b];
		sh_bucket[b] = n;
		bump_refs(n);
		r.node_index = n;
		return r;
	endfunction

	function automatic res_t table_step(input op_t o, input logic [LEVEL_BITS-1:0] lv,
			input logic [NODE_BITS-1:0] lo, input logic [NODE_BITS-1:0] hi,
			input logic [NODE_BITS-1:0] tg);
		res_t r;
		r = '0;
		r.status = ST_OK;
		case (o)
			OP_MAKE: begin
				r = make_node(lv, lo, hi);
			end
			OP_INC: begin
				if (tg > 1)
					bump_refs(tg);
			end
			OP_REL: begin
				r.status = drop_ref(tg);
			end
			default: begin
			end
		endcase
		r.var_count = (sh_levels > 17'hffff) ? 16'hffff : sh_levels[15:0];
		return r;
	endfunction

	function automatic void table_reset();
		for (int i = 0; i < NODE_COUNT; i++) begin
			sh_level[i] = LEVEL_FREE;
			sh_low[i] = '0;
			sh_high[i] = '0;
			sh_refs[i] = '0;
			sh_link[i] = (i >= 2 && i + 1 < NODE_COUNT) ? NODE_BITS'(i + 1) : '0;
		end
		sh_link[NODE_COUNT-1] = 12'd2;
		sh_low[1] = 12'd1;
		sh_high[1] = 12'd1;
		sh_refs[0] = 16'd2;
		sh_refs[1] = 16'd2;
		for (int i = 0; i < BKT_COUNT; i++)
			sh_bucket[i] = '0;
		sh_free_tail = NODE_LAST;
		sh_levels = '0;
	endfunction

	// Offer one transfer and hold it until accepted; sometimes idles in a burst beforehand.
	// push stays high after the transfer so items can follow back to back.
	task automatic send(input op_t o, input logic [LEVEL_BITS-1:0] lv,
			input logic [NODE_BITS-1:0] lo, input logic [NODE_BITS-1:0] hi,
			input logic [NODE_BITS-1:0] tg, input bit chk, input res_t want);
		res_t r;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		push <= 1'b1;
		op <= o;
		var_level <= lv;
		low_child <= lo;
		high_child <= hi;
		target_node <= tg;
		do
			@(posedge clk);
		while (full);
		// accepted at this edge: predict in transfer order
		r = table_step(o, lv, lo, hi, tg);
		if (chk && r != want)
			report("directed row vs predictor", 32'(r), 32'(want));
		expected_q.push_back(chk ? want : r);
	endtask

	// Result side: pop with random stalls, compare at accepting edges
	always @(posedge clk) begin
		res_t w;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					report("result with nothing expected", 32'(node_index), 32'h0);
				end else begin
					w = expected_q.pop_front();
					if (node_index !== w.node_index)
						report("node_index", 32'(node_index), 32'(w.node_index));
					if (status !== w.status)
						report("status", 32'(status), 32'(w.status));
					if (var_count !== w.var_count)
						report("var_count", 32'(var_count), 32'(w.var_count));
				end
			end
			if (!idle_enable)
				pop <= 1'b1;
			else if (pop && $urandom_range(0, 5) == 0)
				pop <= 1'b0;
			else if (!pop && $urandom_range(0, 2) == 0)
				pop <= 1'b1;
		end
	end

	// Watchdog over cycles with no transfer on either side; covers the clearing pass
	// and the longest chain walks
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 200000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [NODE_BITS-1:0] pick_live();
		int k;
		for (int t = 0; t < 8; t++) begin
			k = $urandom_range(2, NODE_COUNT - 1);
			if (sh_level[k] != LEVEL_FREE)
				return NODE_BITS'(k);
		end
		return NODE_BITS'($urandom_range(0, 31));
	endfunction

	row_t rows [$];
	logic [NODE_BITS-1:0] made [$];

	initial begin
		res_t z;
		row_t rw;
		op_t  o;
		logic [LEVEL_BITS-1:0] lv;
		logic [NODE_BITS-1:0]  lo, hi, tg;
		int sel;
		z = '0;
		table_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: equal children, constants, first allocation, extremes
		rows = '{
			'{OP_NOP,  16'h0000, 12'h000, 12'h000, 12'h000, 1, '{12'h000, ST_OK, 16'h0}},
			'{OP_MAKE, 16'h0005, 12'h000, 12'h000, 12'h000, 1, '{12'h000, ST_OK, 16'h0}},
			'{OP_MAKE, 16'h0005, 12'h001, 12'h001, 12'h000, 1, '{12'h001, ST_OK, 16'h0}},
			'{OP_INC,  16'h0000, 12'h000, 12'h000, 12'h001, 1, '{12'h000, ST_OK, 16'h0}},
			'{OP_REL,  16'h0000, 12'h000, 12'h000, 12'h000, 1, '{12'h000, ST_OK, 16'h0}},
			'{OP_REL,  16'h0000, 12'h000, 12'h000, 12'h005, 1, '{12'h000, ST_ZERO, 16'h0}},
			'{OP_MAKE, 16'h0000, 12'h000, 12'h001, 12'h000, 1, '{12'h002, ST_OK, 16'h1}},
			'{OP_MAKE, 16'h0000, 12'h000, 12'h001, 12'h000, 1, '{12'h002, ST_OK, 16'h1}},
			'{OP_MAKE, 16'hfffe, 12'h001, 12'h000, 12'h000, 1, '{12'h003, ST_OK, 16'hffff}},
			'{OP_MAKE, 16'hffff, 12'h002, 12'h003, 12'h000, 0, z},
			'{OP_MAKE, 16'h0003, 12'hfff, 12'h002, 12'h000, 0, z},
			'{OP_MAKE, 16'h0007, 12'h004, 12'hfff, 12'h000, 0, z},
			'{OP_REL,  16'h0000, 12'h000, 12'h000, 12'h002, 0, z},
			'{OP_REL,  16'h0000, 12'h000, 12'h000, 12'h002, 0, z},
			'{OP_REL,  16'h0000, 12'h000, 12'h000, 12'h002, 0, z},
			'{OP_INC,  16'h0000, 12'h000, 12'h000, 12'hfff, 0, z},
			'{OP_REL,  16'h0000, 12'h000, 12'h000, 12'hfff, 0, z},
			'{OP_REL,  16'h0000, 12'h000, 12'h000, 12'h003, 0, z},
			'{OP_MAKE, 16'haaaa, 12'h555, 12'haaa, 12'h000, 0, z},
			'{OP_MAKE, 16'h5555, 12'haaa, 12'h555, 12'h000, 0, z},
			'{OP_INC,  16'h0000, 12'h000, 12'h000, 12'h004, 0, z},
			'{OP_NOP,  16'hffff, 12'hfff, 12'hfff, 12'hfff, 0, z}
		};
		foreach (rows[i]) begin
			rw = rows[i];
			send(rw.o, rw.lv, rw.lo, rw.hi, rw.tg, rw.chk, rw.want);
		end
		push <= 1'b0;

		// Hold off until the queue drains at least once
		wait (expected_q.size() == 0);
		@(posedge clk);

		// Random: mostly makes over recent nodes so chains and reuse get exercised
		for (int i = 0; i < 1600; i++) begin
			if (i == 1400)
				idle_enable = 1'b0;
			sel = $urandom_range(0, 99);
			lv = (sel % 7 == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
			lo = (made.size() > 0 && $urandom_range(0, 2) != 0)
				? made[$urandom_range(0, made.size() - 1)] : 12'($urandom_range(0, 3));
			hi = (made.size() > 0 && $urandom_range(0, 1) != 0)
				? made[$urandom_range(0, made.size() - 1)] : 12'($urandom);
			tg = (made.size() > 0 && $urandom_range(0, 3) != 0)
				? made[$urandom_range(0, made.size() - 1)] : pick_live();
			if (sel < 55)
				o = OP_MAKE;
			else if (sel < 70)
				o = OP_INC;
			else if (sel < 95)
				o = OP_REL;
			else
				o = OP_NOP;
			send(o, lv, lo, hi, tg, 1'b0, z);
			if (o == OP_MAKE && expected_q[$].node_index > 1) begin
				made.push_back(expected_q[$].node_index);
				if (made.size() > 48)
					void'(made.pop_front());
			end
		end
		push <= 1'b0;

		wait (expected_q.size() == 0);
		repeat (100) @(posedge clk);
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
